>>> hdl/nbdc_pkg.sv
// Package for the negative/positive base digit converter.
// Holds sizes, state and register codes, and the digit-to-ASCII mapping.
// No dependencies.
`timescale 1ns / 1ps

package nbdc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 33;

    localparam int MAG_W   = VALUE_WIDTH;
    localparam int BIT_W   = $clog2(MAG_W);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [DIGIT_W-1:0] MAG_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] MAG_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd9;
    localparam logic [CHAR_W-1:0]  ALPHA_OFS = 7'd55;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR = 7'h30;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_MAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_NEG = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_RD,
        ST_OUT
    } state_t;

    function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        return (d > DEC_LIMIT) ? (dx + ALPHA_OFS) : (dx + ZERO_CHAR);
    endfunction

endpackage

>>> hdl/nbdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used as the digit buffer of the converter.
`timescale 1ns / 1ps

module nbdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/negabase_digit_conversion.sv
// Radix conversion of an unsigned value to base +B or -B, ASCII digits out.
// Per digit: one quotient bit a cycle on the shared restoring divider, then a
// fix-up step that writes the digit to the buffer RAM. Emission per digit: a
// buffer RAM read, then the output item, which holds while digit_stall is high.
// One item at a time.
// Reset (rst_n low, async): idle, no output, radix reset to -2.
`timescale 1ns / 1ps

module negabase_digit_conversion
    import nbdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  value_valid,
    output logic                  value_stall,
    input  logic [31:0]           value,
    // result items
    output logic                  digit_valid,
    input  logic                  digit_stall,
    output logic [CHAR_W-1:0]     digit_char,
    output logic                  is_last,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [DIGIT_W-1:0] base_mag_reg;
    logic               base_neg_reg;
    logic [DIGIT_W-1:0] mag;

    // Sequencer and datapath
    state_t             state_reg, state_next;
    logic [MAG_W-1:0]   q_reg, q_next;       // dividend shifting out, quotient shifting in
    logic [DIGIT_W-1:0] rem_reg, rem_next;   // partial remainder, always below mag
    logic               sign_reg, sign_next; // sign of the remaining value
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;   // digits written so far
    logic [IDX_W-1:0]   ptr_reg, ptr_next;   // emission pointer, counts down

    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W:0]   trial_diff;
    logic               trial_ge;
    logic               fix_up;
    logic [MAG_W-1:0]   new_mag;
    logic               new_sign;
    logic [DIGIT_W-1:0] digit;

    logic               ram_we;
    logic               ram_re;
    logic [DIGIT_W-1:0] ram_rdata;

    localparam logic [BIT_W-1:0] BIT_LAST   = BIT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(MAX_DIGITS - 1);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mag_reg <= MAG_MIN;
            base_neg_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_MAG: base_mag_reg <= cfg_data;
                REG_BASE_NEG: base_neg_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Out-of-range magnitudes clamp to 2..36
    always_comb
    begin
        if (base_mag_reg < MAG_MIN)
            mag = MAG_MIN;
        else if (base_mag_reg > MAG_MAX)
            mag = MAG_MAX;
        else
            mag = base_mag_reg;
    end

    // Restoring divider step: shift next dividend bit into the remainder
    assign trial      = {rem_reg, q_reg[MAG_W-1]};
    assign trial_diff = trial - {1'b0, mag};
    assign trial_ge   = (trial >= {1'b0, mag});

    // Signed step from |v| = Q*mag + R:
    //  v >= 0: digit R, quotient Q (negated for negative radix).
    //  v < 0 : remainder -R; if nonzero, digit mag-R and quotient Q+1.
    // Only negative radix ever makes v negative.
    assign fix_up   = sign_reg && (rem_reg != '0);
    assign new_mag  = q_reg + {{(MAG_W-1){1'b0}}, fix_up};
    assign new_sign = base_neg_reg && !sign_reg && (q_reg != '0);
    assign digit    = fix_up ? (mag - rem_reg) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        sign_reg <= sign_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        sign_next   = sign_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        value_stall = (state_reg != ST_IDLE);
        digit_valid = (state_reg == ST_OUT);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    q_next     = value[MAG_W-1:0];
                    rem_next   = '0;
                    sign_next  = 1'b0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
                q_next   = {q_reg[MAG_W-2:0], trial_ge};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_LAST)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                // write digit, reload divider with the new remaining value
                ram_we    = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                q_next    = new_mag;
                sign_next = new_sign;
                rem_next  = '0;
                bit_next  = '0;
                if ((new_mag == '0) || (cnt_reg == CNT_LAST))
                begin
                    ptr_next   = cnt_reg[IDX_W-1:0];
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!digit_stall)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digit buffer, least significant digit at index 0
    nbdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (digit),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Read data holds while stalled: the RAM reads only in ST_RD
    assign digit_char = to_char(ram_rdata);
    assign is_last    = (ptr_reg == '0);

endmodule

>>> hdl/nbdc_checker.sv
// Port-level checks for the digit converter, bound to the top level.
// Depends on nbdc_pkg and negabase_digit_conversion.
`timescale 1ns / 1ps

module nbdc_checker
    import nbdc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  value_valid,
    input logic                  value_stall,
    input logic                  digit_valid,
    input logic                  digit_stall,
    input logic [CHAR_W-1:0]     digit_char,
    input logic                  is_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid && $stable(digit_char) && $stable(is_last))
        else $error("result changed while stalled");

    // after taking an item the block is busy and no digit is out yet
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall && !digit_valid)
        else $error("not busy after accepting an item");

    // one item at a time: no input taken while digits go out
    a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> value_stall)
        else $error("input open while emitting");

    // characters are 0-9 or A-Z
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> ((digit_char >= 7'h30) && (digit_char <= 7'h39)) ||
                        ((digit_char >= 7'h41) && (digit_char <= 7'h5A)))
        else $error("digit character out of range");

endmodule

bind negabase_digit_conversion nbdc_checker u_nbdc_checker (.*);

>>> sim/nbdc_digit_checker.sv
// Checker for negabase_digit_conversion: tracks config writes, predicts digit
// items for every accepted value item, and compares them to the result stream.
// Depends on nbdc_pkg for widths and register codes.
`timescale 1ns / 1ps

module nbdc_digit_checker
    import nbdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    input  logic                  value_stall,
    input  logic [31:0]           value,
    input  logic                  digit_valid,
    input  logic                  digit_stall,
    input  logic [CHAR_W-1:0]     digit_char,
    input  logic                  is_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    values_seen,
    output int                    digits_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_item_t;

    digit_item_t       digits_due[$];
    logic [DIGIT_W-1:0] radix_mag;
    logic               radix_neg;

    // Converts v with the current radix and queues its digits, most significant first.
    function automatic void queue_digits(input logic [31:0] v);
        longint             mag;
        longint             radix;
        longint             quo;
        longint             rem;
        logic [DIGIT_W-1:0] lsd_first [MAX_DIGITS];
        logic [7:0]         ascii;
        digit_item_t        item;
        int                 n;
        mag = radix_mag;
        if (mag < MAG_MIN) mag = MAG_MIN;
        if (mag > MAG_MAX) mag = MAG_MAX;
        radix = radix_neg ? -mag : mag;
        quo = v;
        n = 0;
        do
        begin
            rem = quo % radix;
            quo = quo / radix;
            if (rem < 0)
            begin
                rem += mag;
                quo += 1;
            end
            lsd_first[n] = rem[DIGIT_W-1:0];
            n++;
        end while (quo != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            ascii = (lsd_first[k] < 10) ? 8'd48 + lsd_first[k] : 8'd65 + lsd_first[k] - 8'd10;
            item.ch = ascii[CHAR_W-1:0];
            item.last = (k == 0);
            digits_due = {digits_due, item};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digit_item_t want;
        if (!rst_n)
        begin
            radix_mag = MAG_MIN;
            radix_neg = 1'b1;
            digits_due.delete();
            fail_count = 0;
            values_seen = 0;
            digits_checked = 0;
            pending = 0;
        end
        else
        begin
            // results first, so a value taken at the same edge queues behind them
            if (digit_valid && !digit_stall)
            begin
                if (digits_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: digit item with nothing due: char %0d last %0b",
                                 $realtime, digit_char, is_last);
                end
                else
                begin
                    want = digits_due.pop_front();
                    digits_checked++;
                    if (want.ch !== digit_char || want.last !== is_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: digit item: exp char %0d last %0b, ",
                                      "got char %0d last %0b"},
                                     $realtime, want.ch, want.last, digit_char, is_last);
                    end
                end
            end
            if (value_valid && !value_stall)
            begin
                queue_digits(value);
                values_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BASE_MAG)
                    radix_mag = cfg_data;
                else if (cfg_index == REG_BASE_NEG)
                    radix_neg = cfg_data[0];
            end
            pending = digits_due.size();
        end
    end

endmodule

>>> sim/tb_negabase_digit_conversion.sv
// Top of the negabase_digit_conversion testbench: clock, reset, stimulus and verdict.
// Depends on nbdc_pkg, the RTL block and nbdc_digit_checker.
`timescale 1ns / 1ps

module tb_negabase_digit_conversion
    import nbdc_pkg::*;
();

    // watchdog: cycles without any accepted item
    localparam int STALL_LIMIT = 20000;
    // quiet cycles after the last digit before touching config or finishing
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  value_valid;
    logic                  value_stall;
    logic [31:0]           value;
    logic                  digit_valid;
    logic                  digit_stall;
    logic [CHAR_W-1:0]     digit_char;
    logic                  is_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int         fail_count;
    int         pending;
    int         values_seen;
    int         digits_checked;
    int         quiet_cycles;
    idle_mode_t idle_mode;

    // radix per random phase; magnitudes 0, 1, 37 and 63 exercise the clamping
    int unsigned phase_mag [NUM_PHASES] = '{36, 2, 10, 0, 63, 1, 37, 7};
    int unsigned phase_neg [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 0};

    negabase_digit_conversion uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit_char  (digit_char),
        .is_last     (is_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    nbdc_digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .value_valid    (value_valid),
        .value_stall    (value_stall),
        .value          (value),
        .digit_valid    (digit_valid),
        .digit_stall    (digit_stall),
        .digit_char     (digit_char),
        .is_last        (is_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .values_seen    (values_seen),
        .digits_checked (digits_checked)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result side: random stall on the receiver-idle phases
    always @(negedge clk)
    begin
        if (idle_mode == IDLE_RECV)
            digit_stall <= ($urandom_range(99) < 70);
        else if (idle_mode == IDLE_BOTH)
            digit_stall <= ($urandom_range(99) < 27);
        else
            digit_stall <= 1'b0;
    end

    // watchdog on accepted items of any channel
    always @(posedge clk)
    begin
        if ((value_valid && !value_stall) || (digit_valid && !digit_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles with no item accepted", STALL_LIMIT);
            $display("negabase_digit_conversion: mismatch");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge after the item is taken.
    // valid stays high between back-to-back items; only sender gaps and drain drop it.
    task automatic send_value(input logic [31:0] v);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 70 : (idle_mode == IDLE_BOTH) ? 27 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            value_valid <= 1'b0;
            value <= $urandom;
            @(negedge clk);
        end
        value_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (value_stall);
        @(negedge clk);
    endtask

    // One register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drops the sender, waits until every due digit is out, then lets the block settle.
    task automatic drain;
        value_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_radix(input int unsigned mag, input int unsigned neg);
        drain();
        write_reg(REG_BASE_MAG, mag[CFG_DATA_W-1:0]);
        write_reg(REG_BASE_NEG, neg[CFG_DATA_W-1:0]);
    endtask

    // Mix of full-width, short, truncated-width and edge values.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(0, 100);
            2: v = $urandom >> $urandom_range(31);
            default:
            begin
                case ($urandom_range(3))
                    0: v = 32'd0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'd1 << $urandom_range(31);
                    default: v = (32'd1 << $urandom_range(31)) - 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        value_valid = 1'b0;
        value = '0;
        digit_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_MAG;
        cfg_data = '0;
        quiet_cycles = 0;
        idle_mode = IDLE_NONE;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset radix is -2, longest digit strings live here
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hAAAA_AAAA);
        send_value(32'h5555_5555);
        send_value(32'h7FFF_FFFF);
        // +36: letters up to 'Z'
        set_radix(36, 0);
        send_value(32'd0);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'hFFFF_FFFF);
        // magnitude 0 clamps up to 2, positive: 32 digits
        set_radix(0, 0);
        send_value(32'hFFFF_FFFF);
        send_value(32'd5);
        // magnitude 63 clamps down to 36, negative
        set_radix(63, 1);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'hFFFF_FFFF);
        // magnitude 1 clamps up, negative
        set_radix(1, 1);
        send_value(32'd6);
        // just above range, positive
        set_radix(37, 0);
        send_value(32'd123456789);

        // random phases, rotating through the idle modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                set_radix($urandom_range(63), $urandom_range(1));
            else
                set_radix(phase_mag[p], phase_neg[p]);
            idle_mode = idle_mode_t'(p % 4);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_value(pick_value());
        end

        drain();
        $display("converted %0d values into %0d checked digits over %0d radix settings",
                 values_seen, digits_checked, NUM_PHASES + 6);
        $display("idle modes covered: none, sender gaps, receiver stalls, both");
        if (fail_count == 0 && pending == 0)
            $display("negabase_digit_conversion: match");
        else
            $display("negabase_digit_conversion: mismatch");
        $finish;
    end

endmodule
